// ----- hw/rtl/skyline_key_points_macros.svh -----
// ----------------------------------------------------------------------------
// Skyline key points: assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SKYLINE_KEY_POINTS_MACROS_SVH
`define SKYLINE_KEY_POINTS_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SKYP_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("skyline key points: assertion failed");
// Next-cycle implication.
`define SKYP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("skyline key points: assertion failed");
`else
`define SKYP_ASSERT(label, clk, rstn, ante, cons)
`define SKYP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- hw/rtl/skyp_pkg.sv -----
// ----------------------------------------------------------------------------
// Skyline key points: package
// Shared constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package skyp_pkg;

    localparam int MaxBldg   = 32;
    localparam int IdxW      = $clog2(MaxBldg);
    localparam int CntW      = $clog2(MaxBldg + 1);
    localparam int CoordW    = 31;
    localparam int InTdataW  = ((3 * CoordW + 7) / 8) * 8;
    localparam int OutTdataW = ((2 * CoordW + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_HEIGHT,
        ST_DECIDE,
        ST_FINAL
    } skyp_state_t;

    typedef struct packed {
        logic load_bldg;
        logic start_coord;
        logic step_coord;
        logic commit_coord;
        logic step_height;
        logic take_point;
        logic finish;
    } skyp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic coord_got;
        logic height_changed;
        logic pend_valid;
        logic out_free;
    } skyp_status_t;

endpackage

// ----- hw/rtl/skyp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Skyline key points: controller
// Sequences loading, the edge coordinate scan, the height scan and output.
// ----------------------------------------------------------------------------
module skyp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tlast,
    output logic                   s_tready,
    input  skyp_pkg::skyp_status_t status,
    output skyp_pkg::skyp_cmd_t    cmd
);
    import skyp_pkg::*;

    skyp_state_t state_reg;
    skyp_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_bldg = 1'b1;
                    if (s_tlast) begin
                        cmd.start_coord = 1'b1;
                        state_next      = ST_COORD;
                    end
                end
            end
            ST_COORD: begin
                if (!status.scan_done) begin
                    cmd.step_coord = 1'b1;
                end else if (status.coord_got) begin
                    cmd.commit_coord = 1'b1;
                    state_next       = ST_HEIGHT;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_HEIGHT: begin
                if (!status.scan_done) begin
                    cmd.step_height = 1'b1;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!status.height_changed) begin
                    cmd.start_coord = 1'b1;
                    state_next      = ST_COORD;
                end else if (!status.pend_valid || status.out_free) begin
                    // release the held point, hold the new one until we know it is not last
                    cmd.take_point  = 1'b1;
                    cmd.start_coord = 1'b1;
                    state_next      = ST_COORD;
                end
            end
            ST_FINAL: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/skyp_datapath.sv -----
// ----------------------------------------------------------------------------
// Skyline key points: datapath
// Building table, scan registers, held key point and output register.
// ----------------------------------------------------------------------------
`include "skyline_key_points_macros.svh"

module skyp_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  skyp_pkg::skyp_cmd_t              cmd,
    output skyp_pkg::skyp_status_t           status,
    input  logic [skyp_pkg::InTdataW-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [skyp_pkg::OutTdataW-1:0]   m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);
    import skyp_pkg::*;

    logic [CoordW-1:0] left_table   [MaxBldg];
    logic [CoordW-1:0] right_table  [MaxBldg];
    logic [CoordW-1:0] height_table [MaxBldg];

    logic [CntW-1:0]   cnt_reg;
    logic              ovf_reg;
    logic [CntW-1:0]   entry_reg;
    logic              side_reg;
    logic              got_reg;
    logic              have_prev_reg;
    logic [CoordW-1:0] best_reg;
    logic [CoordW-1:0] x_reg;
    logic [CoordW-1:0] hbest_reg;
    logic [CoordW-1:0] prev_h_reg;
    logic              pend_valid_reg;
    logic [CoordW-1:0] pend_x_reg;
    logic [CoordW-1:0] pend_h_reg;
    logic              m_tvalid_reg;
    logic [CoordW-1:0] out_x_reg;
    logic [CoordW-1:0] out_h_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;

    logic [CoordW-1:0] in_left;
    logic [CoordW-1:0] in_right;
    logic [CoordW-1:0] in_height;
    logic              in_valid_bldg;
    logic              tbl_full;
    logic [IdxW-1:0]   rd_idx;
    logic [CoordW-1:0] rd_left;
    logic [CoordW-1:0] rd_right;
    logic [CoordW-1:0] rd_height;
    logic [CoordW-1:0] cand;
    logic              cand_ok;
    logic              hit;
    logic              out_free;
    logic              out_load;

    assign in_left       = s_tdata[CoordW-1:0];
    assign in_right      = s_tdata[2*CoordW-1:CoordW];
    assign in_height     = s_tdata[3*CoordW-1:2*CoordW];
    assign in_valid_bldg = in_left < in_right;
    assign tbl_full      = cnt_reg == CntW'(MaxBldg);

    assign rd_idx    = entry_reg[IdxW-1:0];
    assign rd_left   = left_table[rd_idx];
    assign rd_right  = right_table[rd_idx];
    assign rd_height = height_table[rd_idx];

    // next edge coordinate: smallest one strictly above the previous coordinate
    assign cand    = side_reg ? rd_right : rd_left;
    assign cand_ok = (!have_prev_reg || (cand > x_reg)) && (!got_reg || (cand < best_reg));
    assign hit     = (rd_left <= x_reg) && (x_reg < rd_right) && (rd_height > hbest_reg);

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (cmd.take_point && pend_valid_reg) || cmd.finish;

    assign status.scan_done      = entry_reg == cnt_reg;
    assign status.coord_got      = got_reg;
    assign status.height_changed = hbest_reg != prev_h_reg;
    assign status.pend_valid     = pend_valid_reg;
    assign status.out_free       = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OutTdataW - 2 * CoordW)'(0), out_h_reg, out_x_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            have_prev_reg  <= 1'b0;
            prev_h_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.load_bldg && in_valid_bldg) begin
                if (tbl_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.commit_coord) begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.take_point) begin
                pend_valid_reg <= 1'b1;
                prev_h_reg     <= hbest_reg;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                cnt_reg        <= '0;
                ovf_reg        <= 1'b0;
                have_prev_reg  <= 1'b0;
                prev_h_reg     <= '0;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // table and scan payload
    always_ff @(posedge aclk) begin
        if (cmd.load_bldg && in_valid_bldg && !tbl_full) begin
            left_table[cnt_reg[IdxW-1:0]]   <= in_left;
            right_table[cnt_reg[IdxW-1:0]]  <= in_right;
            height_table[cnt_reg[IdxW-1:0]] <= in_height;
        end
        if (cmd.start_coord) begin
            entry_reg <= '0;
            side_reg  <= 1'b0;
            got_reg   <= 1'b0;
        end
        if (cmd.step_coord) begin
            if (cand_ok) begin
                best_reg <= cand;
                got_reg  <= 1'b1;
            end
            if (side_reg) begin
                entry_reg <= entry_reg + 1'b1;
            end
            side_reg <= !side_reg;
        end
        if (cmd.commit_coord) begin
            x_reg     <= best_reg;
            entry_reg <= '0;
            hbest_reg <= '0;
        end
        if (cmd.step_height) begin
            if (hit) begin
                hbest_reg <= rd_height;
            end
            entry_reg <= entry_reg + 1'b1;
        end
        if (cmd.take_point) begin
            if (pend_valid_reg) begin
                out_x_reg    <= pend_x_reg;
                out_h_reg    <= pend_h_reg;
                out_last_reg <= 1'b0;
                out_ovf_reg  <= ovf_reg;
            end
            pend_x_reg <= x_reg;
            pend_h_reg <= hbest_reg;
        end
        if (cmd.finish) begin
            out_x_reg    <= pend_valid_reg ? pend_x_reg : '0;
            out_h_reg    <= pend_valid_reg ? pend_h_reg : '0;
            out_last_reg <= 1'b1;
            out_ovf_reg  <= ovf_reg;
        end
    end

    `SKYP_ASSERT(a_cnt_max, aclk, aresetn, 1'b1, cnt_reg <= CntW'(MaxBldg))
    `SKYP_ASSERT(a_load_free, aclk, aresetn, out_load, out_free)
    `SKYP_ASSERT(a_scan_bound, aclk, aresetn, cmd.step_coord || cmd.step_height, entry_reg < cnt_reg)
    `SKYP_ASSERT_NEXT(a_finish_clear, aclk, aresetn, cmd.finish, (cnt_reg == '0) && !ovf_reg && !pend_valid_reg && m_tvalid_reg)

endmodule

// ----- hw/rtl/skyline_key_points.sv -----
// ----------------------------------------------------------------------------
// Skyline key points: top level
// Loads buildings one per item; the item marked last starts the sweep
// that streams out the skyline key points.
// ----------------------------------------------------------------------------
// Load: one item per cycle, no result; the table takes up to 32 buildings.
// Sweep (N stored buildings): each distinct edge coordinate takes an edge scan over
// both edges of every entry, a height scan over every entry and a decide step, over
// at most 2N+1 scans; the first key point appears after the second change is found,
// the last one after the final empty edge scan. Both scans share one table read port.
// Reset (aresetn low, synchronous): empty table, overflow clear, no result held.
module skyline_key_points (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // left_edge [30:0], right_edge [61:31], bldg_height [92:62], zero pad
    input  logic [skyp_pkg::InTdataW-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // point_x [30:0], point_height [61:31], zero pad
    output logic [skyp_pkg::OutTdataW-1:0]   m_tdata,
    output logic                             m_tlast,
    // overflow [0]
    output logic                             m_tuser
);
    import skyp_pkg::*;

    skyp_cmd_t    cmd;
    skyp_status_t status;

    skyp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skyp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
